/* rtl/omvt_pkg.sv */
// Package with shared constants and types for the mean/variance tracker.
`default_nettype none
package omvt_pkg;
	localparam int TASKS_DEF    = 16;
	localparam int CHANNELS_DEF = 5;
	localparam int MAX_CH       = 5;
	localparam int TIDX_W       = 4;
	localparam int CNT_W        = 16;
	localparam int MEAN_W       = 40;
	localparam int SUMSQ_W      = 64;
	localparam int SAMPLE_W     = 32;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_CNT, ST_RD, ST_DIFF, ST_DIV, ST_MUL0, ST_MUL1,
		ST_MUL2, ST_MUL3, ST_WR, ST_OUT
	} state_t;

	// Command handed to the divider.
	typedef struct packed {
		logic                start;
		logic [MEAN_W-1:0]   dividend;
		logic [CNT_W-1:0]    divisor;
	} div_cmd_t;

	// Status returned by the divider.
	typedef struct packed {
		logic                done;
		logic [MEAN_W-1:0]   quotient;
	} div_sts_t;
endpackage
`default_nettype wire

/* rtl/online_mean_variance_tracker_core.sv */
// Top level of the per-task Welford mean and variance tracker.
`default_nettype none
// One item is taken at a time. A clear, or an item whose task is beyond TASKS, passes
// through the count, write and output states only. A record item, for each channel in
// turn, reads its mean and sum from memory, forms the deviation, runs a bit-serial
// division of it by the count, then a 40x40 product built from four 32x32-or-smaller
// partial products, and writes back. After reset a clearing pass zeroes the count memory
// before the first item is accepted; a task whose count is zero reads its means and sums
// as zero, so the channel memory needs no clearing. The finished result moves into an
// output register, so the next item is accepted while it waits; the sequencer holds at
// the end of an item only while the previous result has not been taken.
module online_mean_variance_tracker_core
	import omvt_pkg::*;
#(
	parameter int TASKS    = TASKS_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata from bit 0: task_index[3:0], clk_sample, ist_sample, evt1_sample,
	// evt2_sample, evt3_sample; zero fill to 168 bits
	input  wire logic [167:0] s_tdata,
	// tuser: operation
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata from bit 0: run_count, clk_mean_out, clk_sumsq_out, ist_mean_out,
	// ist_sumsq_out, evt1_mean_out, evt1_sumsq_out, evt2_mean_out, evt2_sumsq_out,
	// evt3_mean_out, evt3_sumsq_out; 536 bits
	output logic [535:0]      m_tdata
);
	localparam int TW     = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int CW     = $clog2(CHANNELS);
	localparam int MW     = $clog2(MAX_CH);
	localparam int DEPTH  = TASKS * CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CLR_W  = $clog2(TASKS + 1);

	state_t state_q, state_d;

	// Memories: counts per task and mean/sum per task and channel.
	logic [CNT_W-1:0]                cnt_mem [TASKS];
	logic [MEAN_W+SUMSQ_W-1:0]       ch_mem  [DEPTH];
	logic [CNT_W-1:0]                cnt_rd_q;
	logic [MEAN_W+SUMSQ_W-1:0]       ch_rd_q;

	logic [CLR_W-1:0]   clr_q;
	logic               op_q;
	logic [TW-1:0]      task_q;
	logic               task_ok_q;
	logic [SAMPLE_W-1:0] smp_q [MAX_CH];
	logic [CW-1:0]      ch_q;
	logic [CNT_W-1:0]   n_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [SUMSQ_W-1:0] sumsq_q;
	logic [MEAN_W-1:0]  xs_q;
	logic               ge_q;
	logic [MEAN_W-1:0]  mag1_q;
	logic [MEAN_W-1:0]  mag2_q;
	logic [SUMSQ_W-1:0] acc_q;
	logic               ovf_q;
	logic [MEAN_W+SUMSQ_W-1:0] res_ch_q [MAX_CH];
	logic [535:0]       out_q;
	logic               mvalid_q;

	div_cmd_t dcmd;
	div_sts_t dsts;

	logic [ADDR_W-1:0]  ch_addr;
	logic [TW-1:0]      cnt_addr;
	logic [3:0]         in_task;
	logic [CNT_W-1:0]   n_next;
	logic               fresh;
	logic [MEAN_W-1:0]  rd_mean;
	logic [SUMSQ_W-1:0] rd_sumsq;
	logic [MEAN_W-1:0]  x_cur;
	logic               ge_cur;
	logic [MEAN_W-1:0]  mag1_cur;
	logic [MEAN_W-1:0]  mean_new;
	logic [MEAN_W-1:0]  pp_a;
	logic [MEAN_W-1:0]  pp_b;
	logic [63:0]        pp;
	logic [SUMSQ_W:0]   acc_sum;
	logic [SUMSQ_W:0]   fin_sum;
	logic [SUMSQ_W-1:0] sumsq_new;
	logic               last_ch;
	logic               out_free;
	logic [535:0]       res_word;

	assign in_task  = s_tdata[3:0];
	assign ch_addr  = ADDR_W'(task_q * CHANNELS) + ADDR_W'(ch_q);
	assign cnt_addr = (state_q == ST_IDLE) ? TW'(in_task) : task_q;
	assign last_ch  = (ch_q == CW'(CHANNELS - 1));
	assign out_free = !mvalid_q || m_tready;

	omvt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.sts    (dsts)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (clr_q == CLR_W'(TASKS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (s_tvalid) state_d = ST_CNT;
			ST_CNT: begin
				if (!task_ok_q || op_q == OP_CLEAR) state_d = ST_WR;
				else state_d = ST_RD;
			end
			ST_RD:   state_d = ST_DIFF;
			ST_DIFF: state_d = ST_DIV;
			ST_DIV:  if (dsts.done) state_d = ST_MUL0;
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_WR;
			ST_WR: begin
				if (!task_ok_q || op_q == OP_CLEAR || last_ch) state_d = ST_OUT;
				else state_d = ST_RD;
			end
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		dcmd.start     = (state_q == ST_DIFF);
		dcmd.dividend  = mag1_cur;
		dcmd.divisor   = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			clr_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) clr_q <= clr_q + 1'b1;
			if (state_q == ST_OUT && out_free) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

	// New count of the addressed task.
	assign n_next = (op_q == OP_CLEAR) ? '0 :
		(cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;

	// Memory ports: one write and one registered read each.
	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cnt_addr];
		ch_rd_q  <= ch_mem[ch_addr];
		if (state_q == ST_INIT) begin
			cnt_mem[clr_q[TW-1:0]] <= '0;
		end else if (state_q == ST_CNT && task_ok_q) begin
			cnt_mem[task_q] <= n_next;
		end
		if (state_q == ST_WR && task_ok_q) begin
			ch_mem[ch_addr] <= {mean_q, sumsq_q};
		end
	end

	// Old statistics of the channel; a task with no samples reads as zero.
	assign fresh    = (n_q == CNT_W'(1));
	assign rd_mean  = fresh ? '0 : ch_rd_q[MEAN_W+SUMSQ_W-1:SUMSQ_W];
	assign rd_sumsq = fresh ? '0 : ch_rd_q[SUMSQ_W-1:0];
	assign x_cur    = {smp_q[MW'(ch_q)], 8'd0};
	assign ge_cur   = (x_cur >= rd_mean);
	assign mag1_cur = ge_cur ? x_cur - rd_mean : rd_mean - x_cur;

	// Mean update and partial products of the 40x40 square term.
	assign mean_new = ge_q ? (mean_q + dsts.quotient) : (mean_q - dsts.quotient);
	always_comb begin
		case (state_q)
			ST_MUL0: begin pp_a = mag1_q; pp_b = mag2_q; end
			default: begin pp_a = mag1_q; pp_b = mag2_q; end
		endcase
		case (state_q)
			ST_MUL0: pp = {32'd0, pp_a[31:0]} * {32'd0, pp_b[31:0]};
			ST_MUL1: pp = {56'd0, pp_a[39:32]} * {32'd0, pp_b[31:0]};
			ST_MUL2: pp = {32'd0, pp_a[31:0]} * {56'd0, pp_b[39:32]};
			default: pp = {56'd0, pp_a[39:32]} * {56'd0, pp_b[39:32]};
		endcase
	end
	assign acc_sum = {1'b0, acc_q} + {1'b0, (state_q == ST_MUL0) ? (pp >> 16) :
		(state_q == ST_MUL3) ? {pp[15:0], 48'd0} : {pp[47:0], 16'd0}};

	// Saturating accumulate of the square term into the sum after the last partial product.
	assign fin_sum   = {1'b0, sumsq_q} + {1'b0, acc_sum[SUMSQ_W-1:0]};
	assign sumsq_new = (ovf_q || acc_sum[SUMSQ_W] || (pp[63:16] != '0) || fin_sum[SUMSQ_W]) ?
		'1 : fin_sum[SUMSQ_W-1:0];

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q      <= s_tuser;
					task_q    <= TW'(in_task);
					task_ok_q <= ({28'd0, in_task} < 32'(TASKS));
					for (int c = 0; c < MAX_CH; c++)
						smp_q[c] <= s_tdata[4 + SAMPLE_W*c +: SAMPLE_W];
					ch_q      <= '0;
				end
			end
			ST_CNT: begin
				n_q     <= n_next;
				mean_q  <= '0;
				sumsq_q <= '0;
			end
			ST_DIFF: begin
				mean_q  <= rd_mean;
				sumsq_q <= rd_sumsq;
				xs_q    <= x_cur;
				ge_q    <= ge_cur;
				mag1_q  <= mag1_cur;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
			end
			ST_DIV: begin
				if (dsts.done) begin
					mean_q <= mean_new;
					mag2_q <= ge_q ? xs_q - mean_new : mean_new - xs_q;
				end
			end
			ST_MUL0, ST_MUL1, ST_MUL2: begin
				acc_q <= acc_sum[SUMSQ_W-1:0];
				ovf_q <= ovf_q | acc_sum[SUMSQ_W] | ((state_q != ST_MUL0) && (pp[63:48] != '0));
			end
			ST_MUL3: begin
				acc_q   <= acc_sum[SUMSQ_W-1:0];
				ovf_q   <= ovf_q | acc_sum[SUMSQ_W] | (pp[63:16] != '0);
				sumsq_q <= sumsq_new;
			end
			ST_WR: begin
				if (task_ok_q && op_q == OP_RECORD) begin
					res_ch_q[MW'(ch_q)] <= {mean_q, sumsq_q};
					ch_q <= ch_q + 1'b1;
				end else begin
					for (int c = 0; c < MAX_CH; c++) res_ch_q[c] <= '0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_IDLE) begin
			for (int c = 0; c < MAX_CH; c++)
				if (c >= CHANNELS) res_ch_q[c] <= '0;
		end
		if (state_q == ST_OUT && out_free) out_q <= res_word;
	end

	// Result word handed to the output register.
	always_comb begin
		res_word = '0;
		res_word[CNT_W-1:0] = task_ok_q ? n_q : '0;
		for (int c = 0; c < MAX_CH; c++) begin
			res_word[CNT_W + (MEAN_W+SUMSQ_W)*c +: MEAN_W] =
				res_ch_q[c][MEAN_W+SUMSQ_W-1:SUMSQ_W];
			res_word[CNT_W + (MEAN_W+SUMSQ_W)*c + MEAN_W +: SUMSQ_W] =
				res_ch_q[c][SUMSQ_W-1:0];
		end
	end
	assign m_tdata  = out_q;
	assign m_tvalid = mvalid_q;
endmodule
`default_nettype wire

/* rtl/omvt_div.sv */
// Radix-2 restoring divider: 40-bit dividend by 16-bit divisor, one bit per cycle.
`default_nettype none
module omvt_div
	import omvt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_cmd_t cmd,
	output div_sts_t      sts
);
	localparam int STEP_W = $clog2(MEAN_W + 1);

	logic [MEAN_W-1:0] quo_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		rem_sh  = {rem_q, quo_q[MEAN_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(MEAN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			div_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!rem_sub[CNT_W]) begin
				rem_q <= rem_sub[CNT_W-1:0];
				quo_q <= {quo_q[MEAN_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				quo_q <= {quo_q[MEAN_W-2:0], 1'b0};
			end
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = quo_q;
endmodule
`default_nettype wire
